/* sv/btb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_pkg: shared types, constants and functions
// Field widths, register and operation codes, the bundles that pass between
// the blocks of the text blit engine, and the per-channel colour scaler.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int CIDX_W     = 6;
  localparam int SX_W       = 10;
  localparam int SY_W       = 9;
  localparam int PIX_W      = 32;
  localparam int ADDR_W     = 20;
  localparam int STRIDE_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MEM_AW_MAX = CODE_W + ROW_W;

  // Reset values of the configuration registers.
  localparam logic [PIX_W-1:0]    FG_RESET     = 32'h00ff_ffff;
  localparam logic [PIX_W-1:0]    BG_RESET     = 32'hff00_0000;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd512;

  // Inverted alpha codes with a special meaning.
  localparam logic [7:0] ALPHA_OPAQUE = 8'h00;
  localparam logic [7:0] ALPHA_CLEAR  = 8'hff;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR    = 2'd0,
    REG_BG_COLOR    = 2'd1,
    REG_LINE_STRIDE = 2'd2
  } cfg_reg_t;

  // Configuration as the pixel pipeline sees it, colours already prepared.
  typedef struct packed {
    logic [PIX_W-1:0]    fg_prep;
    logic [PIX_W-1:0]    bg_prep;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  // Request to the font store: one access per cycle.
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [MEM_AW_MAX-1:0] addr;
    logic [7:0]            wr_data;
  } mem_req_t;

  // Occupancy of the pipeline stages.
  typedef struct packed {
    logic v1;
    logic v2;
    logic v3;
  } pipe_stat_t;

  // Scales each of the three 8-bit channels by m/256, rounding down.
  function automatic logic [23:0] scale_rgb(input logic [23:0] rgb,
                                            input logic [7:0] m);
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    pr = rgb[23:16] * m;
    pg = rgb[15:8] * m;
    pb = rgb[7:0] * m;
    return {pr[15:8], pg[15:8], pb[15:8]};
  endfunction

endpackage

`default_nettype wire

/* sv/btb_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_in_if / btb_out_if: word channels of the text blit engine
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface btb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [btb_pkg::CODE_W-1:0]  char_code;
  logic [btb_pkg::ROW_W-1:0]   glyph_row;
  logic [btb_pkg::COL_W-1:0]   glyph_col;
  logic [btb_pkg::CIDX_W-1:0]  char_index;
  logic [btb_pkg::SX_W-1:0]    start_x;
  logic [btb_pkg::SY_W-1:0]    start_y;
  logic [7:0]                  glyph_byte;
  logic [btb_pkg::PIX_W-1:0]   dest_pixel;

  modport source (
    output valid, op, char_code, glyph_row, glyph_col, char_index,
           start_x, start_y, glyph_byte, dest_pixel,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, glyph_row, glyph_col, char_index,
           start_x, start_y, glyph_byte, dest_pixel,
    output ready
  );
endinterface

interface btb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [btb_pkg::ADDR_W-1:0]  pixel_address;
  logic [btb_pkg::PIX_W-1:0]   pixel_value;

  modport source (
    output valid, write_enable, pixel_address, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, pixel_value,
    output ready
  );
endinterface

`default_nettype wire

/* sv/btb_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_cfg_regs: configuration registers
// Holds the colours and the line stride, and keeps a prepared copy of each
// colour with its channels pre-scaled by the inverted alpha.
// ----------------------------------------------------------------------------
module btb_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [btb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btb_pkg::PIX_W-1:0]       cfg_wdata,
  output btb_pkg::cfg_t                        cfg
);

  logic [btb_pkg::PIX_W-1:0]    fg_r;
  logic [btb_pkg::PIX_W-1:0]    bg_r;
  logic [btb_pkg::STRIDE_W-1:0] stride_r;
  logic [btb_pkg::PIX_W-1:0]    fg_prep_r;
  logic [btb_pkg::PIX_W-1:0]    bg_prep_r;
  logic [btb_pkg::PIX_W-1:0]    fg_prep_nxt;
  logic [btb_pkg::PIX_W-1:0]    bg_prep_nxt;

  // A colour that is neither opaque nor clear has its channels scaled by
  // (255 - alpha); the alpha byte itself is kept.
  function automatic logic [btb_pkg::PIX_W-1:0] prepare(
    input logic [btb_pkg::PIX_W-1:0] c
  );
    logic [7:0] a;
    a = c[31:24];
    if (a == btb_pkg::ALPHA_OPAQUE || a == btb_pkg::ALPHA_CLEAR) begin
      return c;
    end
    return {a, btb_pkg::scale_rgb(c[23:0], ~a)};
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= btb_pkg::FG_RESET;
      bg_r     <= btb_pkg::BG_RESET;
      stride_r <= btb_pkg::STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        btb_pkg::REG_FG_COLOR:    fg_r     <= cfg_wdata;
        btb_pkg::REG_BG_COLOR:    bg_r     <= cfg_wdata;
        btb_pkg::REG_LINE_STRIDE: stride_r <= cfg_wdata[btb_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign fg_prep_nxt = prepare(fg_r);
  assign bg_prep_nxt = prepare(bg_r);

  // Prepared colours are registered and follow the registers in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_prep_r <= btb_pkg::FG_RESET;
      bg_prep_r <= btb_pkg::BG_RESET;
    end else begin
      fg_prep_r <= fg_prep_nxt;
      bg_prep_r <= bg_prep_nxt;
    end
  end

  assign cfg.fg_prep = fg_prep_r;
  assign cfg.bg_prep = bg_prep_r;
  assign cfg.stride  = stride_r;

endmodule

`default_nettype wire

/* sv/btb_glyph_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_glyph_store: font memory
// Eight bytes per character, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module btb_glyph_store #(
  parameter int FONT_CHARS = 256
) (
  input  wire logic               clk,
  input  wire btb_pkg::mem_req_t  req,
  output logic [7:0]              rd_data
);

  localparam int DEPTH = FONT_CHARS * 8;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/btb_pixel_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_pixel_pipe: three-stage render pipeline
// Stage 1 reads the glyph row and forms the row and column sums, stage 2
// picks the colour and multiplies the row by the stride, stage 3 blends and
// adds up the address. Each stage moves on when the next one is free.
// ----------------------------------------------------------------------------
module btb_pixel_pipe #(
  parameter int FONT_CHARS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire btb_pkg::cfg_t   cfg,
  btb_in_if.sink               in_ch,
  btb_out_if.source            out_ch,
  output btb_pkg::mem_req_t    mem_req,
  input  wire logic [7:0]      glyph_q,
  output btb_pkg::pipe_stat_t  stat
);

  // Stage enables and valid bits.
  logic en1;
  logic en2;
  logic en3;
  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic accept;
  logic is_render;
  logic code_ok;

  // Stage 1 payload.
  logic                          use1_r;
  logic [btb_pkg::COL_W-1:0]     col1_r;
  logic [btb_pkg::SY_W:0]        y1_r;
  logic [btb_pkg::STRIDE_W-1:0]  x1_r;
  logic [btb_pkg::PIX_W-1:0]     dest1_r;
  logic [btb_pkg::SY_W:0]        y1_nxt;
  logic [btb_pkg::STRIDE_W-1:0]  x1_nxt;

  // Stage 2 payload.
  logic [btb_pkg::PIX_W-1:0]     colour2_r;
  logic [btb_pkg::ADDR_W-1:0]    yprod2_r;
  logic [btb_pkg::STRIDE_W-1:0]  x2_r;
  logic [btb_pkg::PIX_W-1:0]     dest2_r;
  logic                          bit_sel;
  logic [btb_pkg::PIX_W-1:0]     colour2_nxt;
  logic [btb_pkg::ADDR_W:0]      yprod_full;

  // Stage 3 (output) payload.
  logic                          we3_r;
  logic [btb_pkg::ADDR_W-1:0]    addr3_r;
  logic [btb_pkg::PIX_W-1:0]     val3_r;
  logic                          we3_nxt;
  logic [btb_pkg::ADDR_W-1:0]    addr3_nxt;
  logic [btb_pkg::PIX_W-1:0]     val3_nxt;
  logic [7:0]                    alpha2;

  // A stage may load when it is empty or the stage after it moves on.
  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;
  assign accept      = in_ch.valid && en1;
  assign is_render   = (in_ch.op == btb_pkg::OP_RENDER);
  assign code_ok     = ({1'b0, in_ch.char_code} < 9'(FONT_CHARS));

  // In-font loads write the store; renders read it. Loads go no further.
  assign mem_req.wr_en   = accept && !is_render && code_ok;
  assign mem_req.rd_en   = accept && is_render;
  assign mem_req.addr    = {in_ch.char_code, in_ch.glyph_row};
  assign mem_req.wr_data = in_ch.glyph_byte;

  // Stage 1: row and column sums.
  assign y1_nxt = {1'b0, in_ch.start_y} + {7'b0, in_ch.glyph_row};
  assign x1_nxt = {1'b0, in_ch.start_x} + {2'b0, in_ch.char_index, 3'b000}
                + {8'b0, in_ch.glyph_col};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid && is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_render) begin
      // The bottom row and codes past the font render as background.
      use1_r  <= code_ok && (in_ch.glyph_row != 3'd7);
      col1_r  <= in_ch.glyph_col;
      y1_r    <= y1_nxt;
      x1_r    <= x1_nxt;
      dest1_r <= in_ch.dest_pixel;
    end
  end

  // Stage 2: glyph bit (bit 7 is the leftmost column) and row offset.
  assign bit_sel     = use1_r && glyph_q[~col1_r];
  assign colour2_nxt = bit_sel ? cfg.fg_prep : cfg.bg_prep;
  assign yprod_full  = {11'b0, y1_r} * {10'b0, cfg.stride};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      colour2_r <= colour2_nxt;
      yprod2_r  <= yprod_full[btb_pkg::ADDR_W-1:0];
      x2_r      <= x1_r;
      dest2_r   <= dest1_r;
    end
  end

  // Stage 3: blend and final address.
  assign alpha2    = colour2_r[31:24];
  assign addr3_nxt = yprod2_r + {9'b0, x2_r};

  always_comb begin
    if (cfg.stride == '0 || alpha2 == btb_pkg::ALPHA_CLEAR) begin
      we3_nxt  = 1'b0;
      val3_nxt = dest2_r;
    end else if (alpha2 == btb_pkg::ALPHA_OPAQUE) begin
      we3_nxt  = 1'b1;
      val3_nxt = colour2_r;
    end else begin
      we3_nxt  = 1'b1;
      val3_nxt = {8'h00, colour2_r[23:0]}
               + {8'h00, btb_pkg::scale_rgb(dest2_r[23:0], alpha2)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      we3_r   <= we3_nxt;
      addr3_r <= addr3_nxt;
      val3_r  <= val3_nxt;
    end
  end

  assign out_ch.valid         = v3_r;
  assign out_ch.write_enable  = we3_r;
  assign out_ch.pixel_address = addr3_r;
  assign out_ch.pixel_value   = val3_r;

  assign stat.v1 = v1_r;
  assign stat.v2 = v2_r;
  assign stat.v3 = v3_r;

endmodule

`default_nettype wire

/* sv/bitmap_text_blit_alpha_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_blit_alpha_blend: text overlay pixel engine
// Stores 8x8 glyph rows and renders one blended framebuffer pixel per
// render word, with its pixel address.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals
//   in_ch     sink       valid/ready, op, glyph fields, dest_pixel
//   out_ch    source     valid/ready, write_enable, pixel_address, pixel_value
//   cfg_*     input      cfg_we, cfg_index, cfg_wdata (write only)
//
// One word is taken in every cycle unless a stall holds the stages; a render
// word's result leaves through three register stages. Load words end at the
// font store write and give no result. Reset clears the valid bits and sets
// the configuration registers to their reset values; the font store holds
// nothing defined until written. A stall on out_ch fills the empty stages
// first and then holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bitmap_text_blit_alpha_blend #(
  parameter int FONT_CHARS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [btb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btb_pkg::PIX_W-1:0]       cfg_wdata,
  btb_in_if.sink                               in_ch,
  btb_out_if.source                            out_ch
);

  btb_pkg::cfg_t       cfg;
  btb_pkg::mem_req_t   mem_req;
  btb_pkg::pipe_stat_t stat;
  logic [7:0]          glyph_q;

  // Configuration registers and prepared colours.
  btb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Font memory.
  btb_glyph_store #(
    .FONT_CHARS (FONT_CHARS)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (glyph_q)
  );

  // Render pipeline.
  btb_pixel_pipe #(
    .FONT_CHARS (FONT_CHARS)
  ) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .glyph_q (glyph_q),
    .stat    (stat)
  );

`ifndef ASSERT_OFF
  // A load word never enters the render stages.
  a_load_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == btb_pkg::OP_LOAD) |=> !stat.v1)
    else $error("load word entered the render pipeline");

  // A render word always occupies the first stage next cycle.
  a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == btb_pkg::OP_RENDER) |=> stat.v1)
    else $error("render word lost at the first stage");

  // With the output stage empty the input side is never held off.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.v3 |-> in_ch.ready)
    else $error("input stalled with an empty output stage");

  // A waiting result stays in the output stage.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.v3 && !out_ch.ready) |=> stat.v3)
    else $error("waiting result dropped from the output stage");

  // Behind a waiting result the middle stage keeps its word.
  a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.v2 && stat.v3 && !out_ch.ready) |=> stat.v2)
    else $error("middle stage word dropped during a stall");
`endif

endmodule

`default_nettype wire
